// ----- hw/rtl/byte_translate_delete_squeeze_assert.svh -----
// Assertion macros shared by the byte filter RTL.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef BYTE_TRANSLATE_DELETE_SQUEEZE_ASSERT_SVH
`define BYTE_TRANSLATE_DELETE_SQUEEZE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active
`define BTDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active
`define BTDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/btds_pkg.sv -----
// Shared constants for the byte translate/delete/squeeze filter.
// No dependencies.
`default_nettype none

package btds_pkg;

    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 1;

    // Input item function codes
    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELETE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_MODE = 2'd1;

endpackage

`default_nettype wire

// ----- hw/rtl/byte_translate_delete_squeeze.sv -----
// Result passes the stage 1, stage 2 and output registers; one item per cycle sustained while no result is stalled.
// Rate is set by a three-stage pipe: map/delete memory read, squeeze memory read at the
// mapped byte, then history compare and the output register.
// Write items give no result. The pipe halts only while a held
// result is stalled. Synchronous active-low reset clears control, history, config
// and the 256 entry valid bits at once (unwritten entries read as zero).
// Depends on btds_pkg and byte_translate_delete_squeeze_assert.svh.
`default_nettype none

`include "byte_translate_delete_squeeze_assert.svh"

module byte_translate_delete_squeeze (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input item channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_func,
    input  wire logic [btds_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire logic                            i_chunk_start,
    input  wire logic                            i_entry_map_on,
    input  wire logic [btds_pkg::BYTE_W-1:0]     i_entry_map_value,
    input  wire logic                            i_entry_delete,
    input  wire logic                            i_entry_squeeze,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [btds_pkg::BYTE_W-1:0]          o_out_byte,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [btds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [btds_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BW  = btds_pkg::BYTE_W;
    localparam int TD  = btds_pkg::TABLE_DEPTH;

    // configuration
    logic r_delete_mode;
    logic r_squeeze_mode;

    // entry memories and their valid bits
    logic [BW+1:0] r_tbl_mem [TD];   // {delete, map_on, map_value}
    logic          r_sq_mem  [TD];
    logic [TD-1:0] r_ent_vld;

    // stage 1
    logic          r1_v;
    logic [BW-1:0] r1_byte;
    logic          r1_start;
    logic [BW+1:0] r1_tbl;
    logic          r1_tbl_vld;

    // stage 2
    logic          r2_v;
    logic [BW-1:0] r2_byte;
    logic          r2_start;
    logic          r2_sq;
    logic          r2_sq_vld;

    // history and output
    logic          r_have_last;
    logic [BW-1:0] r_last_kept;
    logic          r_ov;
    logic [BW-1:0] r_ob;

    logic          adv;
    logic          in_xfer;
    logic          wr_item;
    logic          s1_map_on;
    logic          s1_del;
    logic [BW-1:0] s1_byte;
    logic          s2_have;
    logic          s2_squeeze;
    logic          s2_keep;

    // advance the whole pipe unless a held result is stalled
    assign adv     = !(r_ov && i_stall);
    assign o_stall = !adv;
    assign in_xfer = i_valid && adv;
    assign wr_item = in_xfer && (i_func == btds_pkg::FUNC_WRITE);

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;
    assign o_out_byte  = r_ob;

    // take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delete_mode  <= 1'b0;
            r_squeeze_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == btds_pkg::CFG_DELETE_MODE) begin
                r_delete_mode <= i_cfg_data[0];
            end
            if (i_cfg_index == btds_pkg::CFG_SQUEEZE_MODE) begin
                r_squeeze_mode <= i_cfg_data[0];
            end
        end
    end

    // write entries on write items; mark them valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (wr_item) begin
            r_ent_vld[i_data_byte] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_item) begin
            r_tbl_mem[i_data_byte] <= {i_entry_delete, i_entry_map_on, i_entry_map_value};
            r_sq_mem[i_data_byte]  <= i_entry_squeeze;
        end
    end

    // stage 1: read map and delete entry for the incoming byte
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_tbl     <= r_tbl_mem[i_data_byte];
            r1_tbl_vld <= r_ent_vld[i_data_byte];
            r1_byte    <= i_data_byte;
            r1_start   <= i_chunk_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= in_xfer && (i_func == btds_pkg::FUNC_DATA);
        end
    end

    // delete or translate
    always_comb begin
        s1_map_on = r1_tbl_vld && r1_tbl[BW];
        s1_del    = r_delete_mode && r1_tbl_vld && r1_tbl[BW+1];
        s1_byte   = (!r_delete_mode && s1_map_on) ? r1_tbl[BW-1:0] : r1_byte;
    end

    // stage 2: read squeeze entry at the translated byte
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_sq     <= r_sq_mem[s1_byte];
            r2_sq_vld <= r_ent_vld[s1_byte];
            r2_byte   <= s1_byte;
        end
    end

    // carry a chunk start even when its byte is deleted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v     <= 1'b0;
            r2_start <= 1'b0;
        end else if (adv) begin
            r2_v     <= r1_v && !s1_del;
            r2_start <= r1_v && r1_start;
        end
    end

    // squeeze against the last kept byte of this chunk
    always_comb begin
        s2_have    = r_have_last && !r2_start;
        s2_squeeze = r_squeeze_mode && s2_have && (r2_byte == r_last_kept)
                     && r2_sq_vld && r2_sq;
        s2_keep    = r2_v && !s2_squeeze;
    end

    // update history and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
            r_last_kept <= '0;
            r_ov        <= 1'b0;
        end else if (adv) begin
            r_ov <= s2_keep;
            if (r2_start) begin
                r_have_last <= 1'b0;
            end
            if (s2_keep) begin
                r_have_last <= 1'b1;
                r_last_kept <= r2_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && s2_keep) begin
            r_ob <= r2_byte;
        end
    end

    // checks
    `BTDS_ASSERT_NOW(a_stall_only_when_held, i_clk, i_rst_n, o_stall, r_ov && i_stall)
    `BTDS_ASSERT_NEXT(a_write_marks_valid, i_clk, i_rst_n, wr_item, r_ent_vld[$past(i_data_byte)])
    `BTDS_ASSERT_NEXT(a_deleted_dropped, i_clk, i_rst_n, adv && r1_v && s1_del, !r2_v)
    `BTDS_ASSERT_NEXT(a_keep_updates_hist, i_clk, i_rst_n, adv && s2_keep,
                      r_have_last && r_ov && (r_last_kept == r_ob))

endmodule

`default_nettype wire
